// File: design/ekd_pkg.sv
// Package for the edge-armed key debouncer.
// Field widths, item kind codes, register indexes, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps

package ekd_pkg;

    // Payload widths fixed by the word format
    localparam int FIELD_KEYS = 4;
    localparam int KIND_W     = 2;
    localparam int KEY_W      = 2;
    localparam int CNT_W      = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default key count for the top level
    localparam int DEF_NUM_KEYS = 4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SCAN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INIT = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_PRESS_TICKS   = 1'b0;
    localparam logic REG_RELEASE_TICKS = 1'b1;

    // Register reset values
    localparam logic [CNT_W-1:0] RST_PRESS_TICKS   = 4'd4;
    localparam logic [CNT_W-1:0] RST_RELEASE_TICKS = 4'd4;

    // Broadcast to every lane
    typedef struct packed {
        logic              step;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  press_ticks;
        logic [CNT_W-1:0]  release_ticks;
    } lane_ctrl_t;

    // Status from one lane
    typedef struct packed {
        logic event_now;
        logic pressed_next;
        logic event_next;
    } lane_stat_t;

    // One result word
    typedef struct packed {
        logic [FIELD_KEYS-1:0] pressed_map;
        logic [FIELD_KEYS-1:0] event_map;
        logic                  event_found;
        logic [KEY_W-1:0]      event_key;
    } result_t;

endpackage

// File: design/ekd_if.sv
// Valid/ready channel interfaces for the key debouncer: item in, result out.
// Depends on ekd_pkg for field widths.
`timescale 1ns / 1ps

interface ekd_in_if;
    logic                           valid;
    logic                           ready;
    logic [ekd_pkg::KIND_W-1:0]     kind;
    logic [ekd_pkg::FIELD_KEYS-1:0] fall_flags;
    logic [ekd_pkg::FIELD_KEYS-1:0] level_bits;
    logic [ekd_pkg::KEY_W-1:0]      key_index;

    modport source (output valid, kind, fall_flags, level_bits, key_index, input ready);
    modport sink   (input valid, kind, fall_flags, level_bits, key_index, output ready);
endinterface

interface ekd_out_if;
    logic                           valid;
    logic                           ready;
    logic [ekd_pkg::FIELD_KEYS-1:0] pressed_map;
    logic [ekd_pkg::FIELD_KEYS-1:0] event_map;
    logic                           event_found;
    logic [ekd_pkg::KEY_W-1:0]      event_key;

    modport source (output valid, pressed_map, event_map, event_found, event_key,
                    input ready);
    modport sink   (input valid, pressed_map, event_map, event_found, event_key,
                    output ready);
endinterface

// File: design/ekd_lane.sv
// One key's debouncer: stable/armed/event flags and press/release counters.
// Depends on ekd_pkg.
`timescale 1ns / 1ps

module ekd_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  ekd_pkg::lane_ctrl_t ctrl,
    input  logic                edge_bit,
    input  logic                raw_bit,
    input  logic                clr_event,
    output ekd_pkg::lane_stat_t stat
);

    logic                       pressed_reg, pressed_next;
    logic                       armed_reg, armed_next;
    logic                       event_reg, event_next;
    logic [ekd_pkg::CNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [ekd_pkg::CNT_W-1:0]  rcnt_reg, rcnt_next;

    // Next state for the word in hand
    always_comb
    begin
        logic                      armed_e;
        logic [ekd_pkg::CNT_W-1:0] pcnt_e;
        logic [ekd_pkg::CNT_W-1:0] inc;

        pressed_next = pressed_reg;
        armed_next   = armed_reg;
        event_next   = event_reg;
        pcnt_next    = pcnt_reg;
        rcnt_next    = rcnt_reg;
        armed_e      = armed_reg;
        pcnt_e       = pcnt_reg;
        inc          = '0;

        case (ctrl.kind)
            ekd_pkg::KIND_SCAN:
            begin
                // falling edge arms a released, idle key
                if (edge_bit && !pressed_reg && !armed_reg)
                begin
                    armed_e = 1'b1;
                    pcnt_e  = '0;
                end
                armed_next = armed_e;
                pcnt_next  = pcnt_e;
                if (!pressed_reg && armed_e)
                begin
                    if (raw_bit)
                    begin
                        inc = (pcnt_e < ctrl.press_ticks) ? pcnt_e + 1'b1 : pcnt_e;
                        if (inc >= ctrl.press_ticks)
                        begin
                            pressed_next = 1'b1;
                            event_next   = 1'b1;
                            pcnt_next    = '0;
                            rcnt_next    = '0;
                            armed_next   = 1'b0;
                        end
                        else
                        begin
                            pcnt_next = inc;
                        end
                    end
                    else
                    begin
                        pcnt_next  = '0;
                        armed_next = 1'b0;
                    end
                end
                else if (pressed_reg)
                begin
                    if (!raw_bit)
                    begin
                        inc = (rcnt_reg < ctrl.release_ticks) ? rcnt_reg + 1'b1 : rcnt_reg;
                        if (inc >= ctrl.release_ticks)
                        begin
                            pressed_next = 1'b0;
                            rcnt_next    = '0;
                            pcnt_next    = '0;
                            armed_next   = 1'b0;
                        end
                        else
                        begin
                            rcnt_next = inc;
                        end
                    end
                    else
                    begin
                        rcnt_next  = '0;
                        armed_next = 1'b0;
                    end
                end
            end
            ekd_pkg::KIND_POLL,
            ekd_pkg::KIND_TAKE:
            begin
                if (clr_event)
                    event_next = 1'b0;
            end
            ekd_pkg::KIND_INIT:
            begin
                pressed_next = raw_bit;
                event_next   = 1'b0;
                armed_next   = 1'b0;
                pcnt_next    = '0;
                rcnt_next    = '0;
            end
            default:
            begin
                event_next = event_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            armed_reg   <= 1'b0;
            event_reg   <= 1'b0;
            pcnt_reg    <= '0;
            rcnt_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            pressed_reg <= pressed_next;
            armed_reg   <= armed_next;
            event_reg   <= event_next;
            pcnt_reg    <= pcnt_next;
            rcnt_reg    <= rcnt_next;
        end
    end

    assign stat.event_now    = event_reg;
    assign stat.pressed_next = pressed_next;
    assign stat.event_next   = event_next;

endmodule

// File: design/ekd_merge.sv
// Merging stage: picks the event to consume and builds the result word.
// Depends on ekd_pkg.
`timescale 1ns / 1ps

module ekd_merge #(
    parameter int NUM_KEYS = ekd_pkg::DEF_NUM_KEYS
) (
    input  logic [ekd_pkg::KIND_W-1:0] kind,
    input  logic [ekd_pkg::KEY_W-1:0]  key_index,
    input  logic [NUM_KEYS-1:0]        event_now,
    input  logic [NUM_KEYS-1:0]        pressed_next,
    input  logic [NUM_KEYS-1:0]        event_next,
    output logic [NUM_KEYS-1:0]        grant,
    output ekd_pkg::result_t           result
);

    logic [NUM_KEYS-1:0] lowest;
    logic [NUM_KEYS-1:0] take_sel;

    // lowest pending event, isolated as one bit
    assign lowest = event_now & (~event_now + 1'b1);

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
            take_sel[i] = (int'(key_index) == i) && event_now[i];
    end

    always_comb
    begin
        case (kind)
            ekd_pkg::KIND_POLL: grant = lowest;
            ekd_pkg::KIND_TAKE: grant = take_sel;
            default:            grant = '0;
        endcase
    end

    // result word: maps after the step, plus the consumed key
    always_comb
    begin
        result = '0;
        result.event_found = |grant;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (grant[i])
                result.event_key = result.event_key | ekd_pkg::KEY_W'(i);
        end
        for (int j = 0; j < ekd_pkg::FIELD_KEYS; j++)
        begin
            if (j < NUM_KEYS)
            begin
                result.pressed_map[j] = pressed_next[j];
                result.event_map[j]   = event_next[j];
            end
        end
    end

    always_comb
    begin
        if (!$onehot0(grant))
            $error("more than one event granted");
    end

endmodule

// File: design/edge_armed_key_debouncer.sv
// Top level of the edge-armed key debouncer: lanes, merge, result register, APB registers.
// Depends on ekd_pkg, ekd_if, ekd_lane and ekd_merge.
//
//   channel   dir  handshake      payload
//   key_in    in   valid/ready    kind, fall_flags, level_bits, key_index
//   res_out   out  valid/ready    pressed_map, event_map, event_found, event_key
//   apb       in   psel/penable   press_ticks @0x0, release_ticks @0x4
//
// One word per cycle while key_in.ready is high; its result is registered and appears the cycle after acceptance.
// All lanes update in the acceptance cycle; the merge stage picks poll/take grants.
// key_in.ready is low only while a result waits and res_out.ready is low.
// Reset (rst_n, async low) clears all key state and loads both thresholds with 4.
`timescale 1ns / 1ps

module edge_armed_key_debouncer #(
    parameter int NUM_KEYS = ekd_pkg::DEF_NUM_KEYS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ekd_in_if.sink                         key_in,
    ekd_out_if.source                      res_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ekd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ekd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ekd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [ekd_pkg::CNT_W-1:0] press_ticks_reg, press_ticks_next;
    logic [ekd_pkg::CNT_W-1:0] release_ticks_reg, release_ticks_next;
    logic                      out_valid_reg, out_valid_next;
    ekd_pkg::result_t          res_reg;
    ekd_pkg::result_t          res_next;
    ekd_pkg::lane_ctrl_t       ctrl;
    ekd_pkg::lane_stat_t       stat [NUM_KEYS];
    logic [NUM_KEYS-1:0]       ev_now, pr_next, ev_next, grant;
    logic                      in_acc, cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        press_ticks_next   = press_ticks_reg;
        release_ticks_next = release_ticks_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                ekd_pkg::REG_PRESS_TICKS:   press_ticks_next   = pwdata[ekd_pkg::CNT_W-1:0];
                ekd_pkg::REG_RELEASE_TICKS: release_ticks_next = pwdata[ekd_pkg::CNT_W-1:0];
                default:                    press_ticks_next   = press_ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ekd_pkg::REG_PRESS_TICKS:
                prdata = {{(ekd_pkg::APB_DATA_W-ekd_pkg::CNT_W){1'b0}}, press_ticks_reg};
            ekd_pkg::REG_RELEASE_TICKS:
                prdata = {{(ekd_pkg::APB_DATA_W-ekd_pkg::CNT_W){1'b0}}, release_ticks_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake
    assign in_acc       = key_in.valid && key_in.ready;
    assign key_in.ready = !out_valid_reg || res_out.ready;

    assign ctrl.step          = in_acc;
    assign ctrl.kind          = key_in.kind;
    assign ctrl.press_ticks   = press_ticks_reg;
    assign ctrl.release_ticks = release_ticks_reg;

    // Key lanes; keys beyond the field width see no edges or levels
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        logic edge_bit, raw_bit;

        if (i < ekd_pkg::FIELD_KEYS)
        begin : g_wired
            assign edge_bit = key_in.fall_flags[i];
            assign raw_bit  = key_in.level_bits[i];
        end
        else
        begin : g_idle
            assign edge_bit = 1'b0;
            assign raw_bit  = 1'b0;
        end

        ekd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .edge_bit  (edge_bit),
            .raw_bit   (raw_bit),
            .clr_event (grant[i]),
            .stat      (stat[i])
        );

        assign ev_now[i]  = stat[i].event_now;
        assign pr_next[i] = stat[i].pressed_next;
        assign ev_next[i] = stat[i].event_next;
    end

    ekd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .kind         (key_in.kind),
        .key_index    (key_in.key_index),
        .event_now    (ev_now),
        .pressed_next (pr_next),
        .event_next   (ev_next),
        .grant        (grant),
        .result       (res_next)
    );

    // Result register
    always_comb
    begin
        if (in_acc)
            out_valid_next = 1'b1;
        else if (res_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg   <= ekd_pkg::RST_PRESS_TICKS;
            release_ticks_reg <= ekd_pkg::RST_RELEASE_TICKS;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            press_ticks_reg   <= press_ticks_next;
            release_ticks_reg <= release_ticks_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            res_reg <= res_next;
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.pressed_map = res_reg.pressed_map;
    assign res_out.event_map   = res_reg.event_map;
    assign res_out.event_found = res_reg.event_found;
    assign res_out.event_key   = res_reg.event_key;

    // Checks
    a_take_key: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && key_in.kind == ekd_pkg::KIND_TAKE)
        |=> (!res_reg.event_found || res_reg.event_key == $past(key_in.key_index)))
        else $error("take-event reported a different key");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && key_in.kind == ekd_pkg::KIND_INIT) |=> (res_reg.event_map == '0))
        else $error("init left a pending event");

    a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (key_in.kind == ekd_pkg::KIND_SCAN || key_in.kind == ekd_pkg::KIND_INIT))
        |=> !res_reg.event_found)
        else $error("event consumed by scan or init");

    a_out_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule
